FILE: hw/rtl/tpm_pkg.sv
package tpm_pkg;

    localparam int AccelWidth  = 16;
    localparam int OffsetWidth = AccelWidth + 1;
    localparam int ReportWidth = 8;
    localparam int LedWidth    = 4;
    localparam int CalWidth    = 8;
    localparam int ThrWidth    = 15;
    localparam int CfgIdxWidth = 1;
    localparam int CfgDataWidth = ThrWidth;

    localparam logic signed [AccelWidth-1:0] LowReset  = 16'sd128;
    localparam logic signed [AccelWidth-1:0] HighReset = -16'sd128;
    localparam logic [CalWidth-1:0]          CalSamplesReset    = 8'd50;
    localparam logic [ThrWidth-1:0]          MoveThresholdReset = 15'd1000;

    // offset / 70 as (offset * 7490) >> 19; exact for magnitudes below 43690
    localparam int MoveDivisor = 70;
    localparam int MoveShift   = 19;
    localparam int MoveRecip   = ((1 << MoveShift) + MoveDivisor - 1) / MoveDivisor;
    localparam int RecipWidth  = 13;
    localparam int ProdWidth   = AccelWidth + RecipWidth;

    typedef enum logic
    {
        REQ_SAMPLE = 1'b0,
        REQ_BUTTON = 1'b1
    } req_type_t;

    typedef enum logic [CfgIdxWidth-1:0]
    {
        CFG_CAL_SAMPLES    = 1'b0,
        CFG_MOVE_THRESHOLD = 1'b1
    } cfg_index_t;

    typedef struct packed
    {
        logic                  neg;
        logic [AccelWidth-1:0] mag;
    } axis_off_t;

    typedef struct packed
    {
        axis_off_t x;
        axis_off_t y;
        logic      move_x;
        logic      move_y;
        logic      click;
    } mid_t;

    // Remove the calibration window; below-low is checked first.
    function automatic axis_off_t strip_window(
        input logic signed [AccelWidth-1:0] v,
        input logic signed [AccelWidth-1:0] lo,
        input logic signed [AccelWidth-1:0] hi
    );
        logic signed [OffsetWidth-1:0] ve;
        logic signed [OffsetWidth-1:0] off;
        logic [OffsetWidth-1:0]        neg_off;
        axis_off_t                     res;
        ve = $signed({v[AccelWidth-1], v});
        if (v < lo)
        begin
            off = ve - $signed({lo[AccelWidth-1], lo});
        end
        else if (v > hi)
        begin
            off = ve - $signed({hi[AccelWidth-1], hi});
        end
        else
        begin
            off = '0;
        end
        neg_off = OffsetWidth'(0) - $unsigned(off);
        res.neg = off[OffsetWidth-1];
        res.mag = off[OffsetWidth-1] ? neg_off[AccelWidth-1:0]
                                     : $unsigned(off[AccelWidth-1:0]);
        return res;
    endfunction

    // Truncated divide by 70, saturated to a signed byte; zero when not moving.
    function automatic logic [ReportWidth-1:0] axis_move(
        input axis_off_t a,
        input logic      moving
    );
        logic [ProdWidth-1:0]  prod;
        logic [AccelWidth-1:0] q;
        logic [ReportWidth-1:0] res;
        prod = ProdWidth'(a.mag) * ProdWidth'(MoveRecip);
        q    = AccelWidth'(prod[ProdWidth-1:MoveShift]);
        if (!moving)
        begin
            res = '0;
        end
        else if (!a.neg)
        begin
            res = (q > AccelWidth'(127)) ? 8'h7F : q[ReportWidth-1:0];
        end
        else
        begin
            res = (q >= AccelWidth'(128)) ? 8'h80
                                          : ReportWidth'(0) - q[ReportWidth-1:0];
        end
        return res;
    endfunction

endpackage

FILE: hw/rtl/tilt_to_pointer_motion_unit.sv
// Tilt to pointer motion: takes accelerometer samples and button events, one
// beat per cycle, through three register stages (input, offset, report). The
// first cal_samples samples only widen the per-axis calibration window and
// give no report; later samples give one report beat, or three (press,
// release, motion) when a button event is pending. A click run holds the report
// register for three beats; that and receiver stalls are all that slow the input.
// Button events and calibration samples never wait on the output side.
// Configuration writes are always taken and must be made while idle.
module tilt_to_pointer_motion_unit
(
    input  logic                                      clk,
    input  logic                                      rst_n,

    input  logic                                      cfg_valid,
    output logic                                      cfg_ready,
    input  logic [tpm_pkg::CfgIdxWidth-1:0]           cfg_index,
    input  logic [tpm_pkg::CfgDataWidth-1:0]          cfg_data,

    input  logic                                      in_valid,
    output logic                                      in_ready,
    input  logic                                      req_type,
    input  logic signed [tpm_pkg::AccelWidth-1:0]     accel_x,
    input  logic signed [tpm_pkg::AccelWidth-1:0]     accel_y,

    output logic                                      out_valid,
    input  logic                                      out_ready,
    output logic                                      report_button,
    output logic signed [tpm_pkg::ReportWidth-1:0]    report_x,
    output logic signed [tpm_pkg::ReportWidth-1:0]    report_y,
    output logic [tpm_pkg::LedWidth-1:0]              tilt_leds,
    output logic                                      last_of_run
);

    // configuration
    logic [tpm_pkg::CalWidth-1:0] cal_samples_reg;
    logic [tpm_pkg::ThrWidth-1:0] move_threshold_reg;

    // calibration state
    logic signed [tpm_pkg::AccelWidth-1:0] low_x_reg, low_x_next;
    logic signed [tpm_pkg::AccelWidth-1:0] high_x_reg, high_x_next;
    logic signed [tpm_pkg::AccelWidth-1:0] low_y_reg, low_y_next;
    logic signed [tpm_pkg::AccelWidth-1:0] high_y_reg, high_y_next;
    logic [tpm_pkg::CalWidth-1:0]          samples_seen_reg, samples_seen_next;
    logic                                  click_pending_reg, click_pending_next;

    // input stage
    logic                                  in_valid_reg;
    tpm_pkg::req_type_t                    in_type_reg;
    logic signed [tpm_pkg::AccelWidth-1:0] in_x_reg;
    logic signed [tpm_pkg::AccelWidth-1:0] in_y_reg;

    // offset stage
    logic          mid_valid_reg;
    tpm_pkg::mid_t mid_reg, mid_next;

    // report stage
    logic                            out_valid_reg;
    logic                            out_button_reg;
    logic                            out_last_reg;
    logic [tpm_pkg::ReportWidth-1:0] out_x_reg;
    logic [tpm_pkg::ReportWidth-1:0] out_y_reg;
    logic [tpm_pkg::LedWidth-1:0]    out_leds_reg;

    logic calibrating;
    logic is_button;
    logic in_advance;
    logic in_to_mid;
    logic in_take;
    logic out_take;
    logic out_free;
    logic mid_to_out;
    logic mid_free;
    tpm_pkg::axis_off_t off_x, off_y;
    logic [tpm_pkg::ReportWidth-1:0] move_x, move_y;
    logic [tpm_pkg::LedWidth-1:0]    leds;

    assign cfg_ready = 1'b1;

    assign calibrating = samples_seen_reg < cal_samples_reg;
    assign is_button   = (in_type_reg == tpm_pkg::REQ_BUTTON);

    assign out_take   = out_valid_reg && out_ready;
    assign out_free   = !out_valid_reg || (out_take && out_last_reg);
    assign mid_to_out = mid_valid_reg && out_free;
    assign mid_free   = !mid_valid_reg || mid_to_out;
    // button events and calibration samples retire from the input stage
    assign in_to_mid  = in_valid_reg && !is_button && !calibrating && mid_free;
    assign in_advance = in_valid_reg && (is_button || calibrating || mid_free);
    assign in_ready   = !in_valid_reg || in_advance;
    assign in_take    = in_valid && in_ready;

    always_comb
    begin
        low_x_next         = low_x_reg;
        high_x_next        = high_x_reg;
        low_y_next         = low_y_reg;
        high_y_next        = high_y_reg;
        samples_seen_next  = samples_seen_reg;
        click_pending_next = click_pending_reg;

        off_x = tpm_pkg::strip_window(in_x_reg, low_x_reg, high_x_reg);
        off_y = tpm_pkg::strip_window(in_y_reg, low_y_reg, high_y_reg);

        mid_next.x      = off_x;
        mid_next.y      = off_y;
        mid_next.move_x = off_x.mag > tpm_pkg::AccelWidth'(move_threshold_reg);
        mid_next.move_y = off_y.mag > tpm_pkg::AccelWidth'(move_threshold_reg);
        mid_next.click  = click_pending_reg;

        if (in_valid_reg && is_button)
        begin
            click_pending_next = 1'b1;
        end
        else if (in_valid_reg && calibrating)
        begin
            if (in_x_reg < low_x_reg)
            begin
                low_x_next = in_x_reg;
            end
            if (in_x_reg > high_x_reg)
            begin
                high_x_next = in_x_reg;
            end
            if (in_y_reg < low_y_reg)
            begin
                low_y_next = in_y_reg;
            end
            if (in_y_reg > high_y_reg)
            begin
                high_y_next = in_y_reg;
            end
            samples_seen_next = samples_seen_reg + 1'b1;
        end
        else if (in_to_mid)
        begin
            click_pending_next = 1'b0;
        end
    end

    // x tilt drives report y
    always_comb
    begin
        move_y = tpm_pkg::axis_move(mid_reg.x, mid_reg.move_x);
        move_x = tpm_pkg::axis_move(mid_reg.y, mid_reg.move_y);
        leds   = {mid_reg.move_y && mid_reg.y.neg, mid_reg.move_y && !mid_reg.y.neg,
                  mid_reg.move_x && mid_reg.x.neg, mid_reg.move_x && !mid_reg.x.neg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_samples_reg    <= tpm_pkg::CalSamplesReset;
            move_threshold_reg <= tpm_pkg::MoveThresholdReset;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (tpm_pkg::cfg_index_t'(cfg_index))
                tpm_pkg::CFG_CAL_SAMPLES:
                begin
                    cal_samples_reg <= cfg_data[tpm_pkg::CalWidth-1:0];
                end
                tpm_pkg::CFG_MOVE_THRESHOLD:
                begin
                    move_threshold_reg <= cfg_data[tpm_pkg::ThrWidth-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_x_reg         <= tpm_pkg::LowReset;
            high_x_reg        <= tpm_pkg::HighReset;
            low_y_reg         <= tpm_pkg::LowReset;
            high_y_reg        <= tpm_pkg::HighReset;
            samples_seen_reg  <= '0;
            click_pending_reg <= 1'b0;
        end
        else
        begin
            low_x_reg         <= low_x_next;
            high_x_reg        <= high_x_next;
            low_y_reg         <= low_y_next;
            high_y_reg        <= high_y_next;
            samples_seen_reg  <= samples_seen_next;
            click_pending_reg <= click_pending_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (in_advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_type_reg <= tpm_pkg::req_type_t'(req_type);
            in_x_reg    <= accel_x;
            in_y_reg    <= accel_y;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_valid_reg <= 1'b0;
        end
        else if (in_to_mid)
        begin
            mid_valid_reg <= 1'b1;
        end
        else if (mid_to_out)
        begin
            mid_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_to_mid)
        begin
            mid_reg <= mid_next;
        end
    end

    // click run: press (button, not last) -> release -> motion (last)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            out_button_reg <= 1'b0;
            out_last_reg   <= 1'b0;
        end
        else if (mid_to_out)
        begin
            out_valid_reg  <= 1'b1;
            out_button_reg <= mid_reg.click;
            out_last_reg   <= !mid_reg.click;
        end
        else if (out_take)
        begin
            if (out_last_reg)
            begin
                out_valid_reg <= 1'b0;
            end
            else if (out_button_reg)
            begin
                out_button_reg <= 1'b0;
            end
            else
            begin
                out_last_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mid_to_out)
        begin
            out_x_reg    <= move_x;
            out_y_reg    <= move_y;
            out_leds_reg <= leds;
        end
    end

    assign out_valid     = out_valid_reg;
    assign report_button = out_button_reg;
    assign report_x      = $signed(out_x_reg);
    assign report_y      = $signed(out_y_reg);
    assign tilt_leds     = out_leds_reg;
    assign last_of_run   = out_last_reg;

endmodule

FILE: verif/tb_tilt_to_pointer_motion_unit.sv
module tb_tilt_to_pointer_motion_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import tpm_pkg::*;

    typedef struct packed
    {
        logic                          btn;
        logic signed [ReportWidth-1:0] rx;
        logic signed [ReportWidth-1:0] ry;
        logic [LedWidth-1:0]           leds;
        logic                          last;
    } report_t;

    typedef struct packed
    {
        req_type_t                    req;
        logic signed [AccelWidth-1:0] ax;
        logic signed [AccelWidth-1:0] ay;
        logic                         typed;
        report_t                      want;
    } stim_row_t;

    localparam report_t NoCheck    = '0;
    localparam int      DirRows    = 24;
    localparam int      DirSplit   = 13;
    localparam int      WatchLimit = 2000;

    // rows before DirSplit run with an empty, inverted window (cal 0, thr 1000);
    // the rest after cal 4, thr 0
    localparam stim_row_t DirTab [DirRows] = '{
        '{REQ_SAMPLE, 16'sh0000, 16'sh0000, 1'b1, '{1'b0, 8'sh00, 8'sh00, 4'b0000, 1'b1}},
        '{REQ_SAMPLE, 16'sh7FFF, 16'sh8000, 1'b1, '{1'b0, 8'sh80, 8'sh7F, 4'b1001, 1'b1}},
        '{REQ_SAMPLE, 16'sh8000, 16'sh7FFF, 1'b1, '{1'b0, 8'sh7F, 8'sh80, 4'b0110, 1'b1}},
        '{REQ_SAMPLE, 16'sd872, -16'sd872, 1'b1, '{1'b0, 8'sh00, 8'sh00, 4'b0000, 1'b1}},
        '{REQ_SAMPLE, 16'sd873, -16'sd873, 1'b0, NoCheck},
        '{REQ_BUTTON, 16'sh5A5A, 16'shFFFF, 1'b0, NoCheck},
        '{REQ_SAMPLE, 16'sd9000, -16'sd9000, 1'b0, NoCheck},
        '{REQ_BUTTON, 16'sh0000, 16'sh0000, 1'b0, NoCheck},
        '{REQ_BUTTON, 16'sh7FFF, 16'sh8000, 1'b0, NoCheck},
        '{REQ_SAMPLE, 16'sd128, -16'sd128, 1'b0, NoCheck},
        '{REQ_SAMPLE, -16'sd1, 16'sd1, 1'b0, NoCheck},
        '{REQ_SAMPLE, 16'sd8762, -16'sd8832, 1'b0, NoCheck},
        '{REQ_SAMPLE, 16'sd8832, -16'sd8902, 1'b0, NoCheck},
        '{REQ_BUTTON, 16'sh8000, 16'sh7FFF, 1'b0, NoCheck},
        '{REQ_SAMPLE, 16'sd100, -16'sd50, 1'b0, NoCheck},
        '{REQ_SAMPLE, -16'sd300, 16'sd400, 1'b0, NoCheck},
        '{REQ_SAMPLE, 16'sd50, 16'sd0, 1'b0, NoCheck},
        '{REQ_SAMPLE, 16'sd0, -16'sd200, 1'b0, NoCheck},
        '{REQ_SAMPLE, 16'sd0, 16'sd0, 1'b0, NoCheck},
        '{REQ_SAMPLE, 16'sd101, 16'sd401, 1'b0, NoCheck},
        '{REQ_SAMPLE, -16'sd301, -16'sd201, 1'b0, NoCheck},
        '{REQ_SAMPLE, 16'sd100, 16'sd400, 1'b0, NoCheck},
        '{REQ_SAMPLE, -16'sd300, -16'sd200, 1'b0, NoCheck},
        '{REQ_SAMPLE, 16'sh7FFF, 16'sh8000, 1'b0, NoCheck}
    };

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [CfgIdxWidth-1:0]        cfg_index;
    logic [CfgDataWidth-1:0]       cfg_data;
    logic                          in_valid;
    logic                          in_ready;
    logic                          req_type;
    logic signed [AccelWidth-1:0]  accel_x;
    logic signed [AccelWidth-1:0]  accel_y;
    logic                          out_valid;
    logic                          out_ready;
    logic                          report_button;
    logic signed [ReportWidth-1:0] report_x;
    logic signed [ReportWidth-1:0] report_y;
    logic [LedWidth-1:0]           tilt_leds;
    logic                          last_of_run;

    // typed expectation travels with the input beat
    logic    row_typed;
    report_t row_want;

    // predictor state
    logic [CalWidth-1:0]          cal_len;
    logic [ThrWidth-1:0]          thr_reg;
    logic signed [AccelWidth-1:0] win_lo_x;
    logic signed [AccelWidth-1:0] win_hi_x;
    logic signed [AccelWidth-1:0] win_lo_y;
    logic signed [AccelWidth-1:0] win_hi_y;
    logic [CalWidth-1:0]          cal_count;
    logic                         click_armed;

    report_t motion_q [$];
    int      err_cnt = 0;
    int      quiet_cycles = 0;
    int      stall_left = 0;
    int      run_left = 0;
    bit      idle_en = 1'b1;

    tilt_to_pointer_motion_unit u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .req_type      (req_type),
        .accel_x       (accel_x),
        .accel_y       (accel_y),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .report_button (report_button),
        .report_x      (report_x),
        .report_y      (report_y),
        .tilt_leds     (tilt_leds),
        .last_of_run   (last_of_run)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    function automatic logic signed [OffsetWidth-1:0] window_offset(
        input logic signed [AccelWidth-1:0] v,
        input logic signed [AccelWidth-1:0] lo,
        input logic signed [AccelWidth-1:0] hi
    );
        logic signed [OffsetWidth-1:0] ve;
        logic signed [OffsetWidth-1:0] le;
        logic signed [OffsetWidth-1:0] he;
        ve = OffsetWidth'(v);
        le = OffsetWidth'(lo);
        he = OffsetWidth'(hi);
        // low side first, so an inverted window still gives a negative offset
        if (v < lo)
        begin
            return ve - le;
        end
        if (v > hi)
        begin
            return ve - he;
        end
        return '0;
    endfunction

    function automatic logic signed [ReportWidth-1:0] tilt_step(
        input logic signed [OffsetWidth-1:0] off,
        input logic [ThrWidth-1:0]           thr
    );
        int o;
        int t;
        int m;
        o = int'(off);
        t = int'(thr);
        if (o <= t && o >= -t)
        begin
            return '0;
        end
        m = o / MoveDivisor;
        if (m > 127)
        begin
            m = 127;
        end
        if (m < -128)
        begin
            m = -128;
        end
        return m[ReportWidth-1:0];
    endfunction

    function automatic void tilt_predict(
        input logic                         req,
        input logic signed [AccelWidth-1:0] ax,
        input logic signed [AccelWidth-1:0] ay,
        input logic                         typed,
        input report_t                      want
    );
        logic signed [OffsetWidth-1:0] ox;
        logic signed [OffsetWidth-1:0] oy;
        int                            t;
        report_t                       r;
        if (req == REQ_BUTTON)
        begin
            click_armed = 1'b1;
            return;
        end
        if (cal_count < cal_len)
        begin
            if (ax < win_lo_x) win_lo_x = ax;
            if (ax > win_hi_x) win_hi_x = ax;
            if (ay < win_lo_y) win_lo_y = ay;
            if (ay > win_hi_y) win_hi_y = ay;
            cal_count = cal_count + 8'd1;
            return;
        end
        ox = window_offset(ax, win_lo_x, win_hi_x);
        oy = window_offset(ay, win_lo_y, win_hi_y);
        t  = int'(thr_reg);
        r  = '0;
        r.leds[0] = int'(ox) > t;
        r.leds[1] = int'(ox) < -t;
        r.leds[2] = int'(oy) > t;
        r.leds[3] = int'(oy) < -t;
        // axes swap: x tilt drives report y
        r.ry = tilt_step(ox, thr_reg);
        r.rx = tilt_step(oy, thr_reg);
        if (click_armed)
        begin
            r.btn = 1'b1;
            motion_q.push_back(r);
            r.btn = 1'b0;
            motion_q.push_back(r);
            click_armed = 1'b0;
        end
        r.btn  = 1'b0;
        r.last = 1'b1;
        if (typed)
        begin
            motion_q.push_back(want);
        end
        else
        begin
            motion_q.push_back(r);
        end
    endfunction

    function automatic logic signed [AccelWidth-1:0] tilt_sample(
        input logic signed [AccelWidth-1:0] lo,
        input logic signed [AccelWidth-1:0] hi,
        input logic [ThrWidth-1:0]          thr
    );
        int v;
        int d;
        d = int'($urandom_range(0, int'(thr) + 300));
        case ($urandom_range(0, 9))
            0, 1, 2: v = int'($signed(16'($urandom())));
            3:
            begin
                case ($urandom_range(0, 3))
                    0:       v = 32767;
                    1:       v = -32768;
                    2:       v = 0;
                    default: v = -1;
                endcase
            end
            4, 5, 6: v = int'(lo) - d;
            default: v = int'(hi) + d;
        endcase
        if (v > 32767)
        begin
            v = 32767;
        end
        if (v < -32768)
        begin
            v = -32768;
        end
        return 16'(v);
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch @%0t: %s", $time, what);
        err_cnt++;
    endtask

    // predictor and checker run off the same sampled edge
    always @(posedge clk)
    begin
        report_t got;
        report_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_CAL_SAMPLES)
                begin
                    cal_len = cfg_data[CalWidth-1:0];
                end
                else
                begin
                    thr_reg = cfg_data;
                end
            end
            if (in_valid && in_ready)
            begin
                tilt_predict(req_type, accel_x, accel_y, row_typed, row_want);
            end
            if (out_valid && out_ready)
            begin
                got = {report_button, report_x, report_y, tilt_leds, last_of_run};
                if (motion_q.size() == 0)
                begin
                    report_mismatch("report beat with nothing expected");
                end
                else
                begin
                    want = motion_q.pop_front();
                    if (got.btn !== want.btn)
                        report_mismatch($sformatf("report_button got %0d want %0d",
                                                  got.btn, want.btn));
                    if (got.rx !== want.rx)
                        report_mismatch($sformatf("report_x got %0d want %0d",
                                                  got.rx, want.rx));
                    if (got.ry !== want.ry)
                        report_mismatch($sformatf("report_y got %0d want %0d",
                                                  got.ry, want.ry));
                    if (got.leds !== want.leds)
                        report_mismatch($sformatf("tilt_leds got %b want %b",
                                                  got.leds, want.leds));
                    if (got.last !== want.last)
                        report_mismatch($sformatf("last_of_run got %0d want %0d",
                                                  got.last, want.last));
                end
            end
        end
    end

    // receiver backpressure: random stall bursts between ready runs; always ready once idle_en clears
    always @(posedge clk)
    begin
        if (!idle_en)
        begin
            out_ready <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left--;
        end
        else if (run_left > 0)
        begin
            out_ready <= 1'b1;
            run_left--;
        end
        else if ($urandom_range(0, 1) == 0)
        begin
            out_ready  <= 1'b0;
            stall_left = int'($urandom_range(0, 7));
        end
        else
        begin
            out_ready <= 1'b1;
            run_left  = int'($urandom_range(0, 15));
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WatchLimit)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic send_item(
        input req_type_t                    req,
        input logic signed [AccelWidth-1:0] ax,
        input logic signed [AccelWidth-1:0] ay,
        input logic                         typed,
        input report_t                      want
    );
        if (idle_en && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        req_type  <= req;
        accel_x   <= ax;
        accel_y   <= ay;
        row_typed <= typed;
        row_want  <= want;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CfgDataWidth-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    task automatic write_settings(input logic [CalWidth-1:0] cal, input logic [ThrWidth-1:0] thr);
        write_reg(CFG_CAL_SAMPLES, CfgDataWidth'(cal));
        write_reg(CFG_MOVE_THRESHOLD, thr);
        cfg_valid <= 1'b0;
    endtask

    // calibration samples give no beat, so keep waiting on past the last report
    task automatic settle();
        in_valid <= 1'b0;
        while (motion_q.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic run_random(
        input logic [CalWidth-1:0] cal,
        input logic [ThrWidth-1:0] thr,
        input int                  motion_goal
    );
        int                           cal_left;
        int                           motion;
        logic signed [AccelWidth-1:0] bx;
        logic signed [AccelWidth-1:0] by;
        cal_left = (cal > cal_count) ? int'(cal) - int'(cal_count) : 0;
        motion   = 0;
        while (cal_left > 0 || motion < motion_goal)
        begin
            bx = 16'($urandom());
            by = 16'($urandom());
            if ($urandom_range(0, 99) < 15)
            begin
                send_item(REQ_BUTTON, bx, by, 1'b0, NoCheck);
            end
            else if (cal_left > 0)
            begin
                // keep the window narrow so later samples still move
                bx = 16'(int'($urandom_range(0, 1200)) - 600);
                by = 16'(int'($urandom_range(0, 1200)) - 600);
                send_item(REQ_SAMPLE, bx, by, 1'b0, NoCheck);
                cal_left--;
            end
            else
            begin
                bx = tilt_sample(win_lo_x, win_hi_x, thr);
                by = tilt_sample(win_lo_y, win_hi_y, thr);
                send_item(REQ_SAMPLE, bx, by, 1'b0, NoCheck);
                motion++;
            end
        end
    endtask

    initial
    begin
        logic [CalWidth-1:0] next_cal;
        logic [ThrWidth-1:0] next_thr;

        cal_len     = CalSamplesReset;
        thr_reg     = MoveThresholdReset;
        win_lo_x    = LowReset;
        win_hi_x    = HighReset;
        win_lo_y    = LowReset;
        win_hi_y    = HighReset;
        cal_count   = '0;
        click_armed = 1'b0;

        rst_n     <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        req_type  <= REQ_SAMPLE;
        accel_x   <= '0;
        accel_y   <= '0;
        row_typed <= 1'b0;
        row_want  <= NoCheck;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        settle();

        write_settings(8'd0, MoveThresholdReset);
        for (int i = 0; i < DirRows; i++)
        begin
            if (i == DirSplit)
            begin
                settle();
                write_settings(8'd4, 15'd0);
            end
            send_item(DirTab[i].req, DirTab[i].ax, DirTab[i].ay, DirTab[i].typed,
                      DirTab[i].want);
        end

        settle();
        next_cal = cal_count + 8'd5;
        next_thr = 15'($urandom_range(0, 3000));
        write_settings(next_cal, next_thr);
        run_random(next_cal, next_thr, 20);

        settle();
        write_settings(8'd0, 15'h7FFF);
        run_random(8'd0, 15'h7FFF, 10);

        settle();
        next_cal = cal_count + 8'($urandom_range(1, 6));
        next_thr = 15'($urandom_range(0, 1500));
        write_settings(next_cal, next_thr);
        run_random(next_cal, next_thr, 15);

        // no idling from here on
        settle();
        idle_en  = 1'b0;
        next_cal = cal_count + 8'($urandom_range(1, 4));
        next_thr = 15'($urandom_range(0, 2000));
        write_settings(next_cal, next_thr);
        run_random(next_cal, next_thr, 15);

        settle();
        if (err_cnt == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
